FILE: hdl/edbd_pkg.sv
// ----------------------------------------------------------------------------
// edbd_pkg
// Shared types and constants for the encoder/button dimmer control core.
// ----------------------------------------------------------------------------
package edbd_pkg;

  localparam int unsigned TickBitsDefault = 16;
  localparam int unsigned HistoryBits     = 8;
  localparam int unsigned QueueDepth      = 2;
  localparam int unsigned CfgIndexBits    = 8;
  localparam int unsigned CfgDataBits     = 16;

  // Press detection on the sampled history: two released samples, then
  // three pressed samples.
  localparam logic [HistoryBits-1:0] PressMask    = 8'b1100_0111;
  localparam logic [HistoryBits-1:0] PressPattern = 8'b1100_0000;

  localparam logic [7:0] BrightnessReset = 8'd100;
  localparam logic [7:0] BrightnessMax   = 8'd255;
  localparam logic [7:0] BrightnessMin   = 8'd1;
  localparam logic [7:0] IndicatorLit    = 8'd0;
  localparam logic [7:0] IndicatorDark   = 8'd255;

  // Configuration register indexes
  localparam logic [CfgIndexBits-1:0] RegSampleInterval   = 8'd0;
  localparam logic [CfgIndexBits-1:0] RegDoublePressWin   = 8'd1;
  localparam logic [CfgIndexBits-1:0] RegBrightnessStep   = 8'd2;
  localparam logic [CfgIndexBits-1:0] RegFlashOnTicks     = 8'd3;
  localparam logic [CfgIndexBits-1:0] RegFlashOffTicks    = 8'd4;
  localparam logic [CfgIndexBits-1:0] RegIndicatorNormal  = 8'd5;

  // Configuration reset values
  localparam logic [7:0]  SampleIntervalReset  = 8'd5;
  localparam logic [15:0] DoublePressWinReset  = 16'd100;
  localparam logic [6:0]  BrightnessStepReset  = 7'd5;
  localparam logic [7:0]  FlashOnTicksReset    = 8'd75;
  localparam logic [7:0]  FlashOffTicksReset   = 8'd50;
  localparam logic [7:0]  IndicatorNormalReset = 8'd240;

  // Limit flash phases
  localparam logic [1:0] FlashIdle  = 2'd0;
  localparam logic [1:0] FlashOn1   = 2'd1;
  localparam logic [1:0] FlashOff   = 2'd2;
  localparam logic [1:0] FlashOn2   = 2'd3;

  typedef struct packed {
    logic [7:0]  sample_interval;
    logic [15:0] double_press_window;
    logic [6:0]  brightness_step;
    logic [7:0]  flash_on_ticks;
    logic [7:0]  flash_off_ticks;
    logic [7:0]  indicator_normal_level;
  } edbd_cfg_t;

  typedef struct packed {
    logic button_level;
    logic enc_a_level;
    logic enc_b_level;
  } edbd_item_t;

endpackage

FILE: hdl/encoder_button_dimmer_control_core.sv
// ----------------------------------------------------------------------------
// encoder_button_dimmer_control_core
// Rotary encoder dimmer with a debounced push button and limit flash.
// ----------------------------------------------------------------------------
// Usage:
//   Send one item per system tick on the input channel (in_valid_i /
//   in_ready_o) with the sampled button level (low = pressed) and both
//   encoder pin levels. Each item yields exactly one result transfer on the
//   output channel (out_valid_o / out_ready_i): LED duty, indicator duty,
//   power flag and flash flag after that tick.
//   Path: an item enters a two-entry queue, then the control engine runs
//   the whole tick as one combinational pass and registers the result, so
//   out_valid_o follows the queue register and then the result register.
//   Throughput is one item per cycle while out_ready_i does not stall it.
//   Stall: when the receiver holds out_ready_i low, the result register
//   holds, the engine stops, and the queue keeps taking items until full.
//   Configuration: write registers through cfg_valid_i / cfg_index_i /
//   cfg_data_i while no ticks are in flight; indexes past the list drop.
//   Reset: all timers, history and flash state clear, brightness goes to
//   100, power off, and configuration returns to its defaults.
// ----------------------------------------------------------------------------
module encoder_button_dimmer_control_core import edbd_pkg::*; #(
  parameter int unsigned TICK_BITS = TickBitsDefault
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  // Tick input channel
  input  logic                    in_valid_i,
  output logic                    in_ready_o,
  input  logic                    button_level_i,
  input  logic                    enc_a_level_i,
  input  logic                    enc_b_level_i,
  // Result channel
  output logic                    out_valid_o,
  input  logic                    out_ready_i,
  output logic [7:0]              led_duty_o,
  output logic [7:0]              indicator_duty_o,
  output logic                    powered_o,
  output logic                    flashing_o,
  // Configuration write channel
  input  logic                    cfg_valid_i,
  output logic                    cfg_ready_o,
  input  logic [CfgIndexBits-1:0] cfg_index_i,
  input  logic [CfgDataBits-1:0]  cfg_data_i
);

  edbd_cfg_t  cfg_q;
  edbd_item_t in_item;
  edbd_item_t q_item;
  logic       q_valid;
  logic       q_ready;

  // Configuration writes are always accepted and registered directly.
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.sample_interval        <= SampleIntervalReset;
      cfg_q.double_press_window    <= DoublePressWinReset;
      cfg_q.brightness_step        <= BrightnessStepReset;
      cfg_q.flash_on_ticks         <= FlashOnTicksReset;
      cfg_q.flash_off_ticks        <= FlashOffTicksReset;
      cfg_q.indicator_normal_level <= IndicatorNormalReset;
    end else if (cfg_valid_i && cfg_ready_o) begin
      // Mask each value to its register width; drop unknown indexes.
      unique case (cfg_index_i)
        RegSampleInterval:  cfg_q.sample_interval        <= cfg_data_i[7:0];
        RegDoublePressWin:  cfg_q.double_press_window    <= cfg_data_i[15:0];
        RegBrightnessStep:  cfg_q.brightness_step        <= cfg_data_i[6:0];
        RegFlashOnTicks:    cfg_q.flash_on_ticks         <= cfg_data_i[7:0];
        RegFlashOffTicks:   cfg_q.flash_off_ticks        <= cfg_data_i[7:0];
        RegIndicatorNormal: cfg_q.indicator_normal_level <= cfg_data_i[7:0];
        default: ;
      endcase
    end
  end

  assign in_item.button_level = button_level_i;
  assign in_item.enc_a_level  = enc_a_level_i;
  assign in_item.enc_b_level  = enc_b_level_i;

  // Front end: hold incoming ticks so the input side need not wait on a
  // stalled result until the queue is full.
  edbd_queue u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_item_i   (in_item),
    .pop_valid_o (q_valid),
    .pop_ready_i (q_ready),
    .pop_item_o  (q_item)
  );

  // Back end: one control pass per tick, result registered at the output.
  edbd_engine #(
    .TICK_BITS (TICK_BITS)
  ) u_engine (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cfg_i            (cfg_q),
    .item_valid_i     (q_valid),
    .item_ready_o     (q_ready),
    .item_i           (q_item),
    .out_valid_o      (out_valid_o),
    .out_ready_i      (out_ready_i),
    .led_duty_o       (led_duty_o),
    .indicator_duty_o (indicator_duty_o),
    .powered_o        (powered_o),
    .flashing_o       (flashing_o)
  );

endmodule

FILE: hdl/edbd_queue.sv
// ----------------------------------------------------------------------------
// edbd_queue
// Front end: takes tick samples from the input channel into a short queue.
// ----------------------------------------------------------------------------
module edbd_queue import edbd_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  edbd_item_t in_item_i,
  output logic       pop_valid_o,
  input  logic       pop_ready_i,
  output edbd_item_t pop_item_o
);

  localparam int unsigned PtrBits = (QueueDepth > 1) ? $clog2(QueueDepth) : 1;
  localparam int unsigned CntBits = $clog2(QueueDepth + 1);

  edbd_item_t         mem_q [QueueDepth];
  logic [PtrBits-1:0] wr_ptr_q, wr_ptr_d;
  logic [PtrBits-1:0] rd_ptr_q, rd_ptr_d;
  logic [CntBits-1:0] count_q, count_d;
  logic               push, pop;

  assign in_ready_o  = (count_q != CntBits'(QueueDepth));
  assign pop_valid_o = (count_q != '0);
  assign pop_item_o  = mem_q[rd_ptr_q];
  assign push        = in_valid_i && in_ready_o;
  assign pop         = pop_valid_o && pop_ready_i;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (push) begin
      wr_ptr_d = (wr_ptr_q == PtrBits'(QueueDepth - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (pop) begin
      rd_ptr_d = (rd_ptr_q == PtrBits'(QueueDepth - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (push && !pop) begin
      count_d = count_q + 1'b1;
    end else if (pop && !push) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_ptr_q] <= in_item_i;
    end
  end

endmodule

FILE: hdl/edbd_engine.sv
// ----------------------------------------------------------------------------
// edbd_engine
// Back end: runs one control pass per tick and registers the result.
// ----------------------------------------------------------------------------
module edbd_engine import edbd_pkg::*; #(
  parameter int unsigned TICK_BITS = TickBitsDefault
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  edbd_cfg_t  cfg_i,
  input  logic       item_valid_i,
  output logic       item_ready_o,
  input  edbd_item_t item_i,
  output logic       out_valid_o,
  input  logic       out_ready_i,
  output logic [7:0] led_duty_o,
  output logic [7:0] indicator_duty_o,
  output logic       powered_o,
  output logic       flashing_o
);

  localparam int unsigned CmpBits = (TICK_BITS > 16) ? TICK_BITS : 16;

  logic [TICK_BITS-1:0]   tick_q, tick_d;
  logic [TICK_BITS-1:0]   last_sample_q, last_sample_d;
  logic [TICK_BITS-1:0]   first_press_q, first_press_d;
  logic [TICK_BITS-1:0]   last_edge_q, last_edge_d;
  logic [HistoryBits-1:0] hist_q, hist_d;
  logic                   pending_q, pending_d;
  logic                   prev_a_q, prev_a_d;
  logic signed [7:0]      accum_q, accum_d;
  logic [7:0]             bright_q, bright_d;
  logic                   power_q, power_d;
  logic [1:0]             phase_q, phase_d;
  logic [7:0]             ftimer_q, ftimer_d;

  logic                   out_valid_q;
  logic [7:0]             led_q, ind_q;
  logic                   powered_q, flashing_q;
  logic [7:0]             ind_d;

  logic                   step;
  logic [7:0]             ftimer_inc;
  logic [TICK_BITS-1:0]   since_sample, since_edge, since_press;
  logic signed [15:0]     prod;
  logic signed [16:0]     sum;

  assign item_ready_o = !out_valid_q || out_ready_i;
  assign step         = item_valid_i && item_ready_o;

  always_comb begin
    tick_d        = tick_q + 1'b1;
    last_sample_d = last_sample_q;
    first_press_d = first_press_q;
    last_edge_d   = last_edge_q;
    hist_d        = hist_q;
    pending_d     = pending_q;
    prev_a_d      = prev_a_q;
    accum_d       = accum_q;
    bright_d      = bright_q;
    power_d       = power_q;
    phase_d       = phase_q;
    ftimer_d      = ftimer_q;
    ftimer_inc    = ftimer_q + 1'b1;
    since_sample  = '0;
    since_edge    = '0;
    since_press   = '0;
    prod          = '0;
    sum           = '0;

    // Advance a running flash; inputs are ignored while it lasts.
    if (phase_q != FlashIdle) begin
      ftimer_d = ftimer_inc;
      unique case (phase_q)
        FlashOn1: begin
          if (ftimer_inc >= cfg_i.flash_on_ticks) begin
            phase_d  = FlashOff;
            ftimer_d = '0;
          end
        end
        FlashOff: begin
          if (ftimer_inc >= cfg_i.flash_off_ticks) begin
            phase_d  = FlashOn2;
            ftimer_d = '0;
          end
        end
        FlashOn2: begin
          if (ftimer_inc >= cfg_i.flash_on_ticks) begin
            phase_d  = FlashIdle;
            ftimer_d = '0;
          end
        end
        default: ;
      endcase
    end

    if (phase_d == FlashIdle) begin
      // Button sampling
      since_sample = tick_d - last_sample_q;
      if (since_sample >= TICK_BITS'(cfg_i.sample_interval)) begin
        last_sample_d = tick_d;
        hist_d        = {hist_q[HistoryBits-2:0], item_i.button_level};
      end

      // Encoder edge with hold-off
      since_edge = tick_d - last_edge_q;
      if (since_edge >= TICK_BITS'(cfg_i.sample_interval)) begin
        if (item_i.enc_a_level && !prev_a_q) begin
          last_edge_d = tick_d;
          if (item_i.enc_b_level) begin
            if (accum_q != 8'sh80) accum_d = accum_q - 8'sd1;
          end else begin
            if (accum_q != 8'sh7f) accum_d = accum_q + 8'sd1;
          end
        end
        prev_a_d = item_i.enc_a_level;
      end

      // Press detection
      if ((hist_d & PressMask) == PressPattern) begin
        hist_d = '0;
        if (pending_q) begin
          bright_d  = BrightnessMax;
          power_d   = 1'b1;
          pending_d = 1'b0;
        end else begin
          pending_d     = 1'b1;
          first_press_d = tick_d;
        end
      end

      // Lone press toggles power once the window runs out
      since_press = tick_d - first_press_d;
      if (pending_d &&
          (CmpBits'(since_press) >= CmpBits'(cfg_i.double_press_window))) begin
        power_d   = !power_d;
        pending_d = 1'b0;
      end

      // Apply detents to brightness
      prod = $signed({{8{accum_d[7]}}, accum_d}) *
             $signed({9'd0, cfg_i.brightness_step});
      sum  = $signed({9'd0, bright_d}) + $signed({prod[15], prod});
      if (power_d && (accum_d != 8'sd0)) begin
        if ((accum_d > 8'sd0) && (bright_d == BrightnessMax)) begin
          phase_d  = FlashOn1;
          ftimer_d = '0;
        end else if ((accum_d < 8'sd0) && (bright_d == BrightnessMin)) begin
          phase_d  = FlashOn1;
          ftimer_d = '0;
        end else if (sum > 17'sd255) begin
          bright_d = BrightnessMax;
        end else if (sum < 17'sd1) begin
          bright_d = BrightnessMin;
        end else begin
          bright_d = sum[7:0];
        end
        accum_d = '0;
      end
    end
  end

  always_comb begin
    unique case (phase_d)
      FlashOn1, FlashOn2: ind_d = IndicatorLit;
      FlashOff:           ind_d = IndicatorDark;
      default:            ind_d = cfg_i.indicator_normal_level;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tick_q        <= '0;
      last_sample_q <= '0;
      first_press_q <= '0;
      last_edge_q   <= '0;
      hist_q        <= '0;
      pending_q     <= 1'b0;
      prev_a_q      <= 1'b1;
      accum_q       <= '0;
      bright_q      <= BrightnessReset;
      power_q       <= 1'b0;
      phase_q       <= FlashIdle;
      ftimer_q      <= '0;
      out_valid_q   <= 1'b0;
    end else begin
      if (step) begin
        tick_q        <= tick_d;
        last_sample_q <= last_sample_d;
        first_press_q <= first_press_d;
        last_edge_q   <= last_edge_d;
        hist_q        <= hist_d;
        pending_q     <= pending_d;
        prev_a_q      <= prev_a_d;
        accum_q       <= accum_d;
        bright_q      <= bright_d;
        power_q       <= power_d;
        phase_q       <= phase_d;
        ftimer_q      <= ftimer_d;
        out_valid_q   <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q   <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (step) begin
      led_q      <= power_d ? bright_d : 8'd0;
      ind_q      <= ind_d;
      powered_q  <= power_d;
      flashing_q <= (phase_d != FlashIdle);
    end
  end

  assign out_valid_o      = out_valid_q;
  assign led_duty_o       = led_q;
  assign indicator_duty_o = ind_q;
  assign powered_o        = powered_q;
  assign flashing_o       = flashing_q;

endmodule
